/* design/moi_pkg.sv */
package moi_pkg;

  // Field widths and internal arithmetic widths.
  localparam int COUNT_WIDTH  = 16;
  localparam int CORDIC_STEPS = 24;
  localparam int SUM_W        = COUNT_WIDTH + 2;
  localparam int MUL_W        = (SUM_W > 33) ? SUM_W : 33;
  localparam int PROD_W       = 2 * MUL_W;
  localparam int P1_W         = (SUM_W + 32 > 64) ? 64 : SUM_W + 32;
  localparam int DIST_SHIFT   = 10;
  localparam int SCALED_W     = PROD_W - DIST_SHIFT;
  localparam int XY_W         = 46;
  localparam int VL_W         = 23;
  localparam int VH_W         = XY_W - VL_W;
  localparam int ACC_W        = VL_W + 32;
  localparam int FULL_W       = PROD_W + VL_W;
  localparam int Z_W          = 34;
  localparam int POS_W        = 40;
  localparam int ANG_W        = 32;
  localparam int TIME_W       = 32;
  localparam int CFG_W        = 32;
  localparam int CFG_IDX_W    = 1;
  localparam int ITER_W       = $clog2(CORDIC_STEPS);
  localparam int ATAN_IDX_W   = 5;
  localparam int IN_TDATA_W   = ((4 * COUNT_WIDTH + TIME_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W  = ((2 * POS_W + ANG_W + TIME_W + 7) / 8) * 8;

  // Register reset values and fixed gains.
  localparam logic [CFG_W-1:0] C2D_RESET       = 32'd53974;
  localparam logic [CFG_W-1:0] TURN_GAIN_RESET = 32'd1054884768;
  localparam logic [31:0]      INV_GAIN        = 32'd2608131496;

  // Body displacement limit before rotation.
  localparam logic signed [XY_W-1:0] DISP_LIM = 46'sh400_0000_0000;

  // Position saturation bounds.
  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

  // Rounded arctangent of 2^-i as a binary angle.
  localparam logic [31:0] ATAN_TAB [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10680862, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COUNT_TO_DISTANCE = 1'b0,
    CFG_TURN_GAIN         = 1'b1
  } cfg_reg_t;

  // Operand selection for the shared multiplier.
  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_FC,
    MUL_LC,
    MUL_TC,
    MUL_P1L,
    MUL_P1H,
    MUL_XL,
    MUL_XH,
    MUL_YL,
    MUL_YH
  } mul_op_t;

  // Destination of the product registered in the previous cycle.
  typedef enum logic [3:0] {
    WB_NONE,
    WB_FWD,
    WB_LAT,
    WB_P1,
    WB_TURN_LO,
    WB_TURN_HI,
    WB_XLO,
    WB_XHI,
    WB_YLO,
    WB_YHI
  } wb_op_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_MUL_F,
    ST_MUL_L,
    ST_MUL_T,
    ST_WB_T,
    ST_MUL_P1L,
    ST_MUL_P1H,
    ST_WB_TURN,
    ST_FOLD,
    ST_CORDIC,
    ST_MUL_XL,
    ST_MUL_XH,
    ST_MUL_YL,
    ST_MUL_YH,
    ST_WB_Y,
    ST_UPDATE,
    ST_PUBLISH
  } state_t;

  typedef struct packed {
    logic                  load;
    logic                  clear_pose;
    logic                  fold;
    logic                  cordic;
    logic [ATAN_IDX_W-1:0] iter;
    mul_op_t               mul_op;
    wb_op_t                wb_op;
    logic                  update;
    logic                  publish;
  } cmd_t;

  typedef struct packed {
    logic out_full;
  } status_t;

endpackage

/* design/moi_ctrl.sv */
module moi_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic              req_clear,
  input  moi_pkg::status_t  status,
  output moi_pkg::cmd_t     cmd
);

  moi_pkg::state_t                state;
  moi_pkg::state_t                state_next;
  logic [moi_pkg::ITER_W-1:0]     iter;
  logic [moi_pkg::ITER_W-1:0]     iter_next;
  logic                           last_iter;

  assign s_tready  = (state == moi_pkg::ST_IDLE);
  assign last_iter = (iter == moi_pkg::ITER_W'(moi_pkg::CORDIC_STEPS - 1));

  // State and iteration counter registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= moi_pkg::ST_IDLE;
      iter  <= '0;
    end else begin
      state <= state_next;
      iter  <= iter_next;
    end
  end

  // Iteration counter: cleared at the fold, stepped through the rotation.
  always_comb begin
    iter_next = iter;
    if (state == moi_pkg::ST_FOLD) begin
      iter_next = '0;
    end else if (state == moi_pkg::ST_CORDIC && !last_iter) begin
      iter_next = iter + 1'b1;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      moi_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = req_clear ? moi_pkg::ST_CLEAR : moi_pkg::ST_MUL_F;
        end
      end
      moi_pkg::ST_CLEAR:   state_next = moi_pkg::ST_PUBLISH;
      moi_pkg::ST_MUL_F:   state_next = moi_pkg::ST_MUL_L;
      moi_pkg::ST_MUL_L:   state_next = moi_pkg::ST_MUL_T;
      moi_pkg::ST_MUL_T:   state_next = moi_pkg::ST_WB_T;
      moi_pkg::ST_WB_T:    state_next = moi_pkg::ST_MUL_P1L;
      moi_pkg::ST_MUL_P1L: state_next = moi_pkg::ST_MUL_P1H;
      moi_pkg::ST_MUL_P1H: state_next = moi_pkg::ST_WB_TURN;
      moi_pkg::ST_WB_TURN: state_next = moi_pkg::ST_FOLD;
      moi_pkg::ST_FOLD:    state_next = moi_pkg::ST_CORDIC;
      moi_pkg::ST_CORDIC: begin
        if (last_iter) begin
          state_next = moi_pkg::ST_MUL_XL;
        end
      end
      moi_pkg::ST_MUL_XL:  state_next = moi_pkg::ST_MUL_XH;
      moi_pkg::ST_MUL_XH:  state_next = moi_pkg::ST_MUL_YL;
      moi_pkg::ST_MUL_YL:  state_next = moi_pkg::ST_MUL_YH;
      moi_pkg::ST_MUL_YH:  state_next = moi_pkg::ST_WB_Y;
      moi_pkg::ST_WB_Y:    state_next = moi_pkg::ST_UPDATE;
      moi_pkg::ST_UPDATE:  state_next = moi_pkg::ST_PUBLISH;
      moi_pkg::ST_PUBLISH: begin
        if (!status.out_full) begin
          state_next = moi_pkg::ST_IDLE;
        end
      end
      default:             state_next = moi_pkg::ST_IDLE;
    endcase
  end

  // Datapath commands for each state.
  always_comb begin
    cmd        = '0;
    cmd.mul_op = moi_pkg::MUL_NONE;
    cmd.wb_op  = moi_pkg::WB_NONE;
    cmd.iter   = moi_pkg::ATAN_IDX_W'(iter);
    unique case (state)
      moi_pkg::ST_IDLE:    cmd.load = s_tvalid;
      moi_pkg::ST_CLEAR:   cmd.clear_pose = 1'b1;
      moi_pkg::ST_MUL_F:   cmd.mul_op = moi_pkg::MUL_FC;
      moi_pkg::ST_MUL_L: begin
        cmd.mul_op = moi_pkg::MUL_LC;
        cmd.wb_op  = moi_pkg::WB_FWD;
      end
      moi_pkg::ST_MUL_T: begin
        cmd.mul_op = moi_pkg::MUL_TC;
        cmd.wb_op  = moi_pkg::WB_LAT;
      end
      moi_pkg::ST_WB_T:    cmd.wb_op = moi_pkg::WB_P1;
      moi_pkg::ST_MUL_P1L: cmd.mul_op = moi_pkg::MUL_P1L;
      moi_pkg::ST_MUL_P1H: begin
        cmd.mul_op = moi_pkg::MUL_P1H;
        cmd.wb_op  = moi_pkg::WB_TURN_LO;
      end
      moi_pkg::ST_WB_TURN: cmd.wb_op = moi_pkg::WB_TURN_HI;
      moi_pkg::ST_FOLD:    cmd.fold = 1'b1;
      moi_pkg::ST_CORDIC:  cmd.cordic = 1'b1;
      moi_pkg::ST_MUL_XL:  cmd.mul_op = moi_pkg::MUL_XL;
      moi_pkg::ST_MUL_XH: begin
        cmd.mul_op = moi_pkg::MUL_XH;
        cmd.wb_op  = moi_pkg::WB_XLO;
      end
      moi_pkg::ST_MUL_YL: begin
        cmd.mul_op = moi_pkg::MUL_YL;
        cmd.wb_op  = moi_pkg::WB_XHI;
      end
      moi_pkg::ST_MUL_YH: begin
        cmd.mul_op = moi_pkg::MUL_YH;
        cmd.wb_op  = moi_pkg::WB_YLO;
      end
      moi_pkg::ST_WB_Y:    cmd.wb_op = moi_pkg::WB_YHI;
      moi_pkg::ST_UPDATE:  cmd.update = 1'b1;
      moi_pkg::ST_PUBLISH: cmd.publish = !status.out_full;
      default:             cmd.load = 1'b0;
    endcase
  end

  // The rotation never runs past its last step.
  assert property (@(posedge clk) disable iff (rst)
    (state == moi_pkg::ST_CORDIC) |-> (iter <= moi_pkg::ITER_W'(moi_pkg::CORDIC_STEPS - 1)))
    else $error("rotation step counter out of range");

  // A result is loaded only into a free output slot.
  assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> !status.out_full)
    else $error("result loaded over a pending result");

  // An integrating request starts with the forward multiply.
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !req_clear) |=> (state == moi_pkg::ST_MUL_F))
    else $error("integrating request did not start the sequence");

endmodule

/* design/moi_datapath.sv */
module moi_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  moi_pkg::cmd_t                      cmd,
  output moi_pkg::status_t                   status,
  input  logic [moi_pkg::IN_TDATA_W-1:0]     s_tdata,
  input  logic                               cfg_we,
  input  logic [moi_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [moi_pkg::CFG_W-1:0]          cfg_data,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [moi_pkg::OUT_TDATA_W-1:0]    m_tdata
);

  localparam int CW = moi_pkg::COUNT_WIDTH;

  // Configuration registers.
  logic [moi_pkg::CFG_W-1:0] count_to_distance;
  logic [moi_pkg::CFG_W-1:0] turn_gain;

  // Captured request.
  logic signed [moi_pkg::SUM_W-1:0] sum_f;
  logic signed [moi_pkg::SUM_W-1:0] sum_l;
  logic signed [moi_pkg::SUM_W-1:0] sum_t;
  logic [moi_pkg::TIME_W-1:0]       time_in;

  // Working registers.
  logic signed [moi_pkg::PROD_W-1:0] prod;
  logic [moi_pkg::P1_W-1:0]          p1;
  logic [moi_pkg::ANG_W-1:0]         dh;
  logic [moi_pkg::ACC_W-1:0]         acc;
  logic signed [moi_pkg::XY_W-1:0]   x;
  logic signed [moi_pkg::XY_W-1:0]   y;
  logic signed [moi_pkg::Z_W-1:0]    z;

  // Pose state.
  logic signed [moi_pkg::POS_W-1:0]  x_acc;
  logic signed [moi_pkg::POS_W-1:0]  y_acc;
  logic [moi_pkg::ANG_W-1:0]         heading_acc;
  logic [moi_pkg::TIME_W-1:0]        time_reg;

  // Output register.
  logic [moi_pkg::POS_W-1:0]         out_x;
  logic [moi_pkg::POS_W-1:0]         out_y;
  logic [moi_pkg::ANG_W-1:0]         out_h;
  logic [moi_pkg::TIME_W-1:0]        out_t;

  // Combinational intermediates.
  logic signed [moi_pkg::SUM_W-1:0]    lf;
  logic signed [moi_pkg::SUM_W-1:0]    rf;
  logic signed [moi_pkg::SUM_W-1:0]    rr;
  logic signed [moi_pkg::SUM_W-1:0]    lr;
  logic signed [moi_pkg::MUL_W-1:0]    ma;
  logic signed [moi_pkg::MUL_W-1:0]    mb;
  logic signed [moi_pkg::SCALED_W-1:0] scaled;
  logic signed [moi_pkg::SCALED_W-1:0] lim_pos;
  logic signed [moi_pkg::SCALED_W-1:0] lim_neg;
  logic signed [moi_pkg::SCALED_W-1:0] disp;
  logic signed [moi_pkg::FULL_W-1:0]   full;
  logic signed [moi_pkg::XY_W-1:0]     dx;
  logic signed [moi_pkg::XY_W-1:0]     dy;
  logic signed [moi_pkg::Z_W-1:0]      atan_z;
  logic                                fold_now;
  logic signed [moi_pkg::XY_W:0]       sum_x;
  logic signed [moi_pkg::XY_W:0]       sum_y;
  logic signed [moi_pkg::POS_W-1:0]    sat_x;
  logic signed [moi_pkg::POS_W-1:0]    sat_y;

  assign status.out_full = m_tvalid && !m_tready;
  assign m_tdata = {out_t, out_h, out_y, out_x};

  // Wheel counts sign-extended to the sum width.
  assign lf = moi_pkg::SUM_W'($signed(s_tdata[0 +: CW]));
  assign rf = moi_pkg::SUM_W'($signed(s_tdata[CW +: CW]));
  assign rr = moi_pkg::SUM_W'($signed(s_tdata[2*CW +: CW]));
  assign lr = moi_pkg::SUM_W'($signed(s_tdata[3*CW +: CW]));

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      count_to_distance <= moi_pkg::C2D_RESET;
      turn_gain         <= moi_pkg::TURN_GAIN_RESET;
    end else if (cfg_we) begin
      unique case (moi_pkg::cfg_reg_t'(cfg_index))
        moi_pkg::CFG_COUNT_TO_DISTANCE: count_to_distance <= cfg_data;
        moi_pkg::CFG_TURN_GAIN:         turn_gain         <= cfg_data;
        default:                        turn_gain         <= turn_gain;
      endcase
    end
  end

  // Shared multiplier operand selection.
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.mul_op)
      moi_pkg::MUL_FC: begin
        ma = moi_pkg::MUL_W'(sum_f);
        mb = moi_pkg::MUL_W'(count_to_distance);
      end
      moi_pkg::MUL_LC: begin
        ma = moi_pkg::MUL_W'(sum_l);
        mb = moi_pkg::MUL_W'(count_to_distance);
      end
      moi_pkg::MUL_TC: begin
        ma = moi_pkg::MUL_W'(sum_t);
        mb = moi_pkg::MUL_W'(count_to_distance);
      end
      moi_pkg::MUL_P1L: begin
        ma = moi_pkg::MUL_W'(p1[31:0]);
        mb = moi_pkg::MUL_W'(turn_gain);
      end
      moi_pkg::MUL_P1H: begin
        ma = moi_pkg::MUL_W'($signed(p1[moi_pkg::P1_W-1:32]));
        mb = moi_pkg::MUL_W'(turn_gain);
      end
      moi_pkg::MUL_XL: begin
        ma = moi_pkg::MUL_W'(x[moi_pkg::VL_W-1:0]);
        mb = moi_pkg::MUL_W'(moi_pkg::INV_GAIN);
      end
      moi_pkg::MUL_XH: begin
        ma = moi_pkg::MUL_W'($signed(x[moi_pkg::XY_W-1:moi_pkg::VL_W]));
        mb = moi_pkg::MUL_W'(moi_pkg::INV_GAIN);
      end
      moi_pkg::MUL_YL: begin
        ma = moi_pkg::MUL_W'(y[moi_pkg::VL_W-1:0]);
        mb = moi_pkg::MUL_W'(moi_pkg::INV_GAIN);
      end
      moi_pkg::MUL_YH: begin
        ma = moi_pkg::MUL_W'($signed(y[moi_pkg::XY_W-1:moi_pkg::VL_W]));
        mb = moi_pkg::MUL_W'(moi_pkg::INV_GAIN);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  // Distance scaling (divide by four included) with the displacement limit.
  always_comb begin
    scaled  = $signed(prod[moi_pkg::PROD_W-1:moi_pkg::DIST_SHIFT]);
    lim_pos = moi_pkg::SCALED_W'(moi_pkg::DISP_LIM);
    lim_neg = -lim_pos;
    if (scaled > lim_pos) begin
      disp = lim_pos;
    end else if (scaled < lim_neg) begin
      disp = lim_neg;
    end else begin
      disp = scaled;
    end
  end

  // High partial product of the inverse gain joined with the low one.
  assign full = (moi_pkg::FULL_W'(prod) <<< moi_pkg::VL_W) + moi_pkg::FULL_W'(acc);

  // One CORDIC micro-rotation with floor shifts; each axis moves by the other one.
  assign dx       = y >>> cmd.iter;
  assign dy       = x >>> cmd.iter;
  assign atan_z   = moi_pkg::Z_W'(moi_pkg::ATAN_TAB[cmd.iter]);
  assign fold_now = (heading_acc > 32'h4000_0000) && (heading_acc < 32'hC000_0000);

  // Saturating position sums.
  always_comb begin
    sum_x = (moi_pkg::XY_W + 1)'(x_acc) + (moi_pkg::XY_W + 1)'(x);
    sum_y = (moi_pkg::XY_W + 1)'(y_acc) + (moi_pkg::XY_W + 1)'(y);
    if (sum_x > (moi_pkg::XY_W + 1)'(moi_pkg::POS_MAX)) begin
      sat_x = moi_pkg::POS_MAX;
    end else if (sum_x < (moi_pkg::XY_W + 1)'(moi_pkg::POS_MIN)) begin
      sat_x = moi_pkg::POS_MIN;
    end else begin
      sat_x = sum_x[moi_pkg::POS_W-1:0];
    end
    if (sum_y > (moi_pkg::XY_W + 1)'(moi_pkg::POS_MAX)) begin
      sat_y = moi_pkg::POS_MAX;
    end else if (sum_y < (moi_pkg::XY_W + 1)'(moi_pkg::POS_MIN)) begin
      sat_y = moi_pkg::POS_MIN;
    end else begin
      sat_y = sum_y[moi_pkg::POS_W-1:0];
    end
  end

  // Request capture, multiplier and working registers.
  always_ff @(posedge clk) begin
    prod <= ma * mb;
    if (cmd.load) begin
      sum_f   <= lf + rf + lr + rr;
      sum_l   <= rf + lr - lf - rr;
      sum_t   <= rf + rr - lf - lr;
      time_in <= s_tdata[4*CW +: moi_pkg::TIME_W];
    end
    case (cmd.wb_op)
      moi_pkg::WB_FWD:     x   <= disp[moi_pkg::XY_W-1:0];
      moi_pkg::WB_LAT:     y   <= disp[moi_pkg::XY_W-1:0];
      moi_pkg::WB_P1:      p1  <= prod[moi_pkg::P1_W-1:0];
      moi_pkg::WB_TURN_LO: dh  <= prod[63:32];
      moi_pkg::WB_TURN_HI: dh  <= dh + prod[31:0];
      moi_pkg::WB_XLO:     acc <= prod[moi_pkg::ACC_W-1:0];
      moi_pkg::WB_XHI:     x   <= full[32 +: moi_pkg::XY_W];
      moi_pkg::WB_YLO:     acc <= prod[moi_pkg::ACC_W-1:0];
      moi_pkg::WB_YHI:     y   <= full[32 +: moi_pkg::XY_W];
      default:             acc <= acc;
    endcase
    // Fold the heading into the right half plane, then rotate step by step.
    if (cmd.fold) begin
      if (fold_now) begin
        x <= -x;
        y <= -y;
        z <= moi_pkg::Z_W'($signed(heading_acc ^ 32'h8000_0000));
      end else begin
        z <= moi_pkg::Z_W'($signed(heading_acc));
      end
    end else if (cmd.cordic) begin
      if (!z[moi_pkg::Z_W-1]) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - atan_z;
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + atan_z;
      end
    end
  end

  // Pose state.
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_pose) begin
      x_acc       <= '0;
      y_acc       <= '0;
      heading_acc <= '0;
      time_reg    <= '0;
    end else if (cmd.update) begin
      x_acc       <= sat_x;
      y_acc       <= sat_y;
      heading_acc <= heading_acc + dh;
      time_reg    <= time_in;
    end
  end

  // Output register and its valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.publish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_x <= x_acc;
      out_y <= y_acc;
      out_h <= heading_acc;
      out_t <= time_reg;
    end
  end

  // A clear leaves the whole pose at zero.
  assert property (@(posedge clk) disable iff (rst)
    cmd.clear_pose |=> (x_acc == '0 && y_acc == '0 && heading_acc == '0 && time_reg == '0))
    else $error("pose not zero after clear");

  // A result appears only after a load of the output register.
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(cmd.publish))
    else $error("result valid without a load");

endmodule

/* design/mecanum_odometry_integrator_core.sv */
// A result is valid once its request has passed the multiply, rotation, update and publish states;
// a clear goes straight to publish. Requests are taken one at a time, each run set by the 24-step
// iterative CORDIC rotation and the nine products that go through the one shared multiplier.
// The next request is taken while the previous result still waits in the output register.
// Reset (synchronous, active high) zeroes the pose and time and loads the register defaults.
module mecanum_odometry_integrator_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // lf_count, rf_count, rr_count, lr_count, sample_time from the lowest bit up.
  input  logic [moi_pkg::IN_TDATA_W-1:0]     s_tdata,
  // clear
  input  logic                               s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // pos_x, pos_y, heading, pose_time from the lowest bit up.
  output logic [moi_pkg::OUT_TDATA_W-1:0]    m_tdata,
  input  logic                               cfg_we,
  input  logic [moi_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [moi_pkg::CFG_W-1:0]          cfg_data
);

  moi_pkg::cmd_t    cmd;
  moi_pkg::status_t status;

  // Sequencer.
  moi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .req_clear (s_tuser),
    .status    (status),
    .cmd       (cmd)
  );

  // Arithmetic, pose state and output register.
  moi_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .s_tdata   (s_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

/* tb/sv/pose_checker.sv */
module pose_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  // lf_count, rf_count, rr_count, lr_count, sample_time from the lowest bit up.
  input  logic [moi_pkg::IN_TDATA_W-1:0]  s_tdata,
  // clear
  input  logic                            s_tuser,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  // pos_x, pos_y, heading, pose_time from the lowest bit up.
  input  logic [moi_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  logic                            cfg_we,
  input  logic [moi_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [moi_pkg::CFG_W-1:0]       cfg_data,
  output int                              mismatches,
  output int                              waiting,
  output int                              compared
);
  timeunit 1ns;
  timeprecision 1ps;
  import moi_pkg::*;

  localparam longint POS_HI   = 64'sd549755813887;
  localparam longint POS_LO   = -64'sd549755813888;
  localparam longint BODY_LIM = 64'sd4398046511104;
  localparam logic [31:0] DEFAULT_C2D  = 32'd53974;
  localparam logic [31:0] DEFAULT_TURN = 32'd1054884768;

  // Arctangent of 2^-k as a binary angle, rounded to the nearest unit.
  localparam logic [31:0] ARC_TAN [0:31] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10680862, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  // One pose result, pos_x in the lowest bits as on the output bus.
  typedef struct packed {
    logic [TIME_W-1:0] pose_time;
    logic [ANG_W-1:0]  heading;
    logic [POS_W-1:0]  pos_y;
    logic [POS_W-1:0]  pos_x;
  } pose_t;

  // Pose held by the predictor and the gain registers it mirrors.
  longint      x_pos;
  longint      y_pos;
  logic [31:0] hdg_pos;
  logic [31:0] stamp_pos;
  logic [31:0] meters_per_count;
  logic [31:0] hdg_per_meter;

  pose_t pose_due [$];

  initial begin
    mismatches = 0;
    compared   = 0;
    waiting    = 0;
  end

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Removes the CORDIC growth: floor(v * 0.60725... ) with a 32-bit fraction.
  function automatic longint undo_cordic_gain(longint v);
    logic signed [95:0] wide;
    wide = v;
    wide = (wide * 96'sd2608131496) >>> 32;
    return longint'(wide[63:0]);
  endfunction

  // Integrates one encoder sample into the pose and returns the new pose.
  function automatic pose_t integrate_sample(logic [IN_TDATA_W-1:0] req, logic clr);
    longint      lf, rf, rr, lr;
    longint      fwd_sum, lat_sum, turn_sum, scale;
    longint      vx, vy, z, dx, dy;
    logic [63:0] turn_prod;
    logic [31:0] ang;
    pose_t       res;
    if (clr) begin
      x_pos     = 0;
      y_pos     = 0;
      hdg_pos   = '0;
      stamp_pos = '0;
    end else begin
      lf = $signed(req[0*COUNT_WIDTH +: COUNT_WIDTH]);
      rf = $signed(req[1*COUNT_WIDTH +: COUNT_WIDTH]);
      rr = $signed(req[2*COUNT_WIDTH +: COUNT_WIDTH]);
      lr = $signed(req[3*COUNT_WIDTH +: COUNT_WIDTH]);
      fwd_sum  = lf + rf + lr + rr;
      lat_sum  = -lf + rf + lr - rr;
      turn_sum = -lf + rf - lr + rr;

      // Body motion in Q.24 meters; the divide by four sits in the shift.
      scale = meters_per_count;
      vx = clip((fwd_sum * scale) >>> 10, -BODY_LIM, BODY_LIM);
      vy = clip((lat_sum * scale) >>> 10, -BODY_LIM, BODY_LIM);
      turn_prod = 64'(turn_sum) * 64'(meters_per_count) * 64'(hdg_per_meter);

      // Rotate by the old heading; angles past a quarter turn are folded first.
      ang = hdg_pos;
      if (ang > 32'h4000_0000 && ang < 32'hC000_0000) begin
        vx  = -vx;
        vy  = -vy;
        ang = ang + 32'h8000_0000;
      end
      z = $signed(ang);
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        dx = vy >>> (i % 32);
        dy = vx >>> (i % 32);
        if (z >= 0) begin
          vx = vx - dx;
          vy = vy + dy;
          z  = z - longint'(ARC_TAN[i % 32]);
        end else begin
          vx = vx + dx;
          vy = vy - dy;
          z  = z + longint'(ARC_TAN[i % 32]);
        end
      end
      vx = undo_cordic_gain(vx);
      vy = undo_cordic_gain(vy);

      x_pos     = clip(x_pos + vx, POS_LO, POS_HI);
      y_pos     = clip(y_pos + vy, POS_LO, POS_HI);
      hdg_pos   = hdg_pos + turn_prod[63:32];
      stamp_pos = req[4*COUNT_WIDTH +: TIME_W];
    end
    res.pos_x     = x_pos[POS_W-1:0];
    res.pos_y     = y_pos[POS_W-1:0];
    res.heading   = hdg_pos;
    res.pose_time = stamp_pos;
    return res;
  endfunction

  // Watch both channels and the register port on every rising edge.
  always @(posedge clk) begin : watch
    pose_t got;
    pose_t want;
    if (rst) begin
      x_pos            = 0;
      y_pos            = 0;
      hdg_pos          = '0;
      stamp_pos        = '0;
      meters_per_count = DEFAULT_C2D;
      hdg_per_meter    = DEFAULT_TURN;
      pose_due.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_COUNT_TO_DISTANCE) begin
          meters_per_count = cfg_data;
        end else if (cfg_index == CFG_TURN_GAIN) begin
          hdg_per_meter = cfg_data;
        end
      end

      // Results leave before the new request is predicted; latency keeps them apart.
      if (m_tvalid && m_tready) begin
        got = m_tdata[$bits(pose_t)-1:0];
        if (pose_due.size() == 0) begin
          $error("pose result with no sample outstanding: %h", got);
          mismatches++;
        end else begin
          want = pose_due.pop_front();
          compared++;
          if (got.pos_x !== want.pos_x) begin
            $error("pos_x: expected %0d, got %0d", $signed(want.pos_x), $signed(got.pos_x));
            mismatches++;
          end
          if (got.pos_y !== want.pos_y) begin
            $error("pos_y: expected %0d, got %0d", $signed(want.pos_y), $signed(got.pos_y));
            mismatches++;
          end
          if (got.heading !== want.heading) begin
            $error("heading: expected %0d, got %0d",
                   $signed(want.heading), $signed(got.heading));
            mismatches++;
          end
          if (got.pose_time !== want.pose_time) begin
            $error("pose_time: expected %0d, got %0d", want.pose_time, got.pose_time);
            mismatches++;
          end
        end
      end

      if (s_tvalid && s_tready) begin
        pose_due.push_back(integrate_sample(s_tdata, s_tuser));
      end
    end
    waiting = pose_due.size();
  end

endmodule

/* tb/sv/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import moi_pkg::*;

  localparam int CW = COUNT_WIDTH;
  localparam int PHASE_ITEMS = 225;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata   = '0;
  logic                   s_tuser   = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]       cfg_data  = '0;

  int mismatches;
  int waiting;
  int compared;

  // Stimulus bookkeeping and knobs shared with the receiver.
  bit          quiet       = 1'b1;
  bit          rx_hold_req = 1'b0;
  int          samples     = 0;
  int          clears      = 0;
  int          settings    = 0;
  logic [31:0] stamp_ms    = '0;

  always #5 clk = ~clk;

  mecanum_odometry_integrator_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pose_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .waiting    (waiting),
    .compared   (compared)
  );

  // Mostly no gap, sometimes a short one, rarely a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 97) return $urandom_range(1, 4);
    return $urandom_range(20, 90);
  endfunction

  function automatic logic signed [CW-1:0] pick_count();
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom_range(0, 400) - 200;
      3, 4, 5: return $urandom();
      6:       return {1'b0, {(CW-1){1'b1}}};
      7:       return {1'b1, {(CW-1){1'b0}}};
      default: return $urandom_range(0, 8000) - 4000;
    endcase
  endfunction

  // Present one encoder sample, wait for its acceptance, then maybe idle.
  task automatic offer(input logic signed [CW-1:0] lf, rf, rr, lr,
                       input logic [31:0] t, input bit clr);
    int gap;
    s_tdata  = {t, lr, rr, rf, lf};
    s_tuser  = clr;
    s_tvalid = 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    samples++;
    if (clr) clears++;
    @(negedge clk);
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Stop sending and wait until every predicted pose has come back.
  task automatic drain();
    s_tvalid = 1'b0;
    while (waiting != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic set_gains(input logic [31:0] c2d, input logic [31:0] turn);
    drain();
    write_reg(CFG_COUNT_TO_DISTANCE, c2d);
    write_reg(CFG_TURN_GAIN, turn);
    settings++;
  endtask

  // Either a coherent chassis motion or four unrelated wheel deltas.
  task automatic random_sample();
    logic signed [CW-1:0] lf, rf, rr, lr;
    int  v, l, w;
    bit  clr;
    clr = ($urandom_range(0, 49) == 0);
    if ($urandom_range(0, 3) != 0) begin
      v = pick_count();
      l = pick_count();
      w = pick_count();
      v = v >>> 1;
      l = l >>> 2;
      w = w >>> 2;
      lf = v - l - w;
      rf = v + l + w;
      lr = v + l - w;
      rr = v - l + w;
    end else begin
      lf = pick_count();
      rf = pick_count();
      rr = pick_count();
      lr = pick_count();
    end
    if ($urandom_range(0, 19) == 0) begin
      stamp_ms = $urandom();
    end else begin
      stamp_ms = stamp_ms + $urandom_range(1, 10);
    end
    offer(lf, rf, rr, lr, stamp_ms, clr);
  endtask

  // Receiver: random stalls, and one long hold-off on request.
  initial begin : receiver
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        m_tready = 1'b0;
        repeat (400) @(negedge clk);
        rx_hold_req = 1'b0;
        m_tready    = 1'b1;
      end else if (stall > 0) begin
        m_tready = 1'b0;
        stall--;
      end else begin
        m_tready = 1'b1;
        if (!quiet) stall = pick_gap();
      end
    end
  end

  // Stimulus: directed samples, then random phases under several gain settings.
  initial begin : stimulus
    logic [31:0] c2d, turn;
    repeat (5) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // Reset gains: clear with counts present, rest, pure forward and spin.
    offer(1000, -5, 7, 9, 32'd77, 1'b1);
    offer(0, 0, 0, 0, 32'd0, 1'b0);
    offer(100, 100, 100, 100, 32'd1, 1'b0);
    offer(-300, 300, 300, -300, 32'd2, 1'b0);
    // Full-rate spins walk the heading through all quadrants, folded ones included.
    for (int i = 0; i < 4; i++) begin
      offer(-32768, 32767, 32767, -32768, 32'd3 + i, 1'b0);
      offer(2000, 2100, 1900, 2050, 32'd10 + i, 1'b0);
    end
    offer(32767, 32767, 32767, 32767, 32'hFFFF_FFFF, 1'b0);
    offer(-32768, -32768, -32768, -32768, 32'd0, 1'b0);
    offer(0, 0, 0, 0, 32'hFFFF_FFFF, 1'b1);

    // Largest distance scale: drive x to both rails, then y to its upper rail.
    set_gains(32'hFFFF_FFFF, 32'd0);
    offer(0, 0, 0, 0, 32'd5, 1'b1);
    repeat (2) offer(32767, 32767, 32767, 32767, 32'd6, 1'b0);
    repeat (3) offer(-32768, -32768, -32768, -32768, 32'd7, 1'b0);
    repeat (2) offer(-32768, 32767, -32768, 32767, 32'd8, 1'b0);

    // Random phases, each under its own gain setting.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin c2d = 32'd53974;      turn = 32'd1054884768; end
        1: begin c2d = 32'd0;          turn = 32'd0;          end
        2: begin c2d = 32'hFFFF_FFFF;  turn = 32'hFFFF_FFFF;  end
        3: begin c2d = $urandom_range(20000, 400000); turn = $urandom_range(1 << 28, 1 << 31); end
        default: begin c2d = $urandom(); turn = $urandom(); end
      endcase
      set_gains(c2d, turn);
      quiet = (ph == 4);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == 100 && ph == 2) begin
          // Hold the output long enough that the core backs up into its input.
          rx_hold_req = 1'b1;
          quiet       = 1'b1;
          repeat (10) random_sample();
          quiet       = 1'b0;
        end
        if (n == 150) drain();
        random_sample();
      end
    end

    drain();
    repeat (50) @(negedge clk);
    $display("Integrated %0d odometry samples (%0d pose clears) over %0d gain settings.",
             samples, clears, settings + 1);
    $display("Compared %0d pose results, including rail saturation and a stalled output.",
             compared);
    if (mismatches == 0 && waiting == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin : watchdog
    #12_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
